>>> src/adcor_pkg.sv
// Shared widths, codes and control/status types for the ADC oversampling block.
package adcor_pkg;

  localparam int ADC_BITS  = 10;
  localparam int CHAN_W    = 5;
  localparam int CNT_W     = 8;
  localparam int SUM_W     = 18;
  localparam int VCC_W     = 13;
  localparam int BG_W      = 11;
  localparam int MV_W      = 13;
  localparam int KIND_W    = 2;
  localparam int LREF_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // multiply and divide widths
  localparam int PROD_W   = SUM_W + VCC_W;
  localparam int QUO_W    = PROD_W - ADC_BITS;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] AUTO_CHECK_IDX = CNT_W'(4);

  // mode codes (in_tuser)
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_READING = 1'b1;

  // result kinds (out_tuser)
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VOLTAGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCC_MV       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANDGAP_MV   = 2'd3;

  // last reference codes
  localparam logic [LREF_W-1:0] LREF_UNKNOWN = 2'd2;

  typedef struct packed {
    logic step;        // input transaction taken, update measurement state
    logic mul;         // load product into divider
    logic div;         // one quotient bit
    logic load_final;  // voltage result into output register
  } adcor_cmd_t;

  typedef struct packed {
    logic step_final;  // current input item completes the measurement
  } adcor_stat_t;

endpackage

>>> src/adcor_ctrl.sv
// Controller: handshake, output valid and multiply/divide sequencing.
module adcor_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  adcor_pkg::adcor_stat_t stat,
  output adcor_pkg::adcor_cmd_t  cmd
);
  import adcor_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free, accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd.step       = accept;
    cmd.mul        = 1'b0;
    cmd.div        = 1'b0;
    cmd.load_final = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && stat.step_final) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((accept && !stat.step_final) || cmd.load_final) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/adcor_dp.sv
// Datapath: registers, measurement state, summing, multiplier and serial divider.
module adcor_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tuser,
  input  logic [adcor_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                  cfg_valid,
  input  logic [adcor_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adcor_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  adcor_pkg::adcor_cmd_t                 cmd,
  output adcor_pkg::adcor_stat_t                stat,
  output logic [adcor_pkg::KIND_W-1:0]          out_tuser,
  output logic [adcor_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import adcor_pkg::*;

  // configuration
  logic [CNT_W-1:0] sample_count_r;
  logic             auto_scale_r;
  logic [VCC_W-1:0] vcc_mv_r;
  logic [BG_W-1:0]  bandgap_mv_r;

  // measurement state
  logic              busy_r, busy_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic              ref_r, ref_nxt;
  logic [LREF_W-1:0] last_ref_r, last_ref_nxt;
  logic              dummy_r, dummy_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // divider
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W:0]   trial;
  logic             trial_ge;

  // output payload
  logic [KIND_W-1:0] o_kind_r;
  logic [CHAN_W-1:0] o_chan_r;
  logic              o_ref_r;
  logic              o_disc_r;
  logic [MV_W-1:0]   o_mv_r;

  logic              mode;
  logic [CHAN_W-1:0] in_chan;
  logic [ADC_BITS-1:0] in_smp;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  taken_inc, n_eff;
  logic [VCC_W-1:0]  uref;
  logic [PROD_W-1:0] prod;

  logic [KIND_W-1:0] res_kind;
  logic [CHAN_W-1:0] res_chan;
  logic              res_ref, res_disc, begin_sum, new_ref, final_step;

  assign mode      = in_tuser;
  assign in_chan   = in_tdata[CHAN_W-1:0];
  assign in_smp    = in_tdata[CHAN_W +: ADC_BITS];
  assign sum_add   = sum_r + SUM_W'(in_smp);
  assign taken_inc = taken_r + 1'b1;
  assign n_eff     = (sample_count_r == '0) ? CNT_W'(1) : sample_count_r;
  assign uref      = ref_r ? VCC_W'(bandgap_mv_r) : vcc_mv_r;
  assign prod      = PROD_W'(sum_r) * PROD_W'(uref);

  // one measurement step per accepted input item
  always_comb begin
    busy_nxt     = busy_r;
    chan_nxt     = chan_r;
    ref_nxt      = ref_r;
    last_ref_nxt = last_ref_r;
    dummy_nxt    = dummy_r;
    taken_nxt    = taken_r;
    sum_nxt      = sum_r;
    res_kind     = KIND_REQUEST;
    res_chan     = chan_r;
    res_ref      = ref_r;
    res_disc     = 1'b0;
    begin_sum    = 1'b0;
    new_ref      = ref_r;
    final_step   = 1'b0;
    priority if (mode == MODE_START) begin
      chan_nxt  = in_chan;
      busy_nxt  = 1'b1;
      new_ref   = 1'b0;
      begin_sum = 1'b1;
    end else if (!busy_r) begin
      res_kind = KIND_IGNORED;
      res_chan = '0;
      res_ref  = 1'b0;
    end else if (dummy_r) begin
      dummy_nxt = 1'b0;
    end else if ((taken_r == AUTO_CHECK_IDX) &&
                 (sum_add < SUM_W'(1 << ADC_BITS)) &&
                 !ref_r && auto_scale_r) begin
      new_ref   = 1'b1;
      begin_sum = 1'b1;
    end else begin
      sum_nxt   = sum_add;
      taken_nxt = taken_inc;
      if (taken_inc >= n_eff) begin
        final_step = 1'b1;
        busy_nxt   = 1'b0;
      end
    end
    if (begin_sum) begin
      ref_nxt   = new_ref;
      sum_nxt   = '0;
      taken_nxt = '0;
      res_chan  = chan_nxt;
      res_ref   = new_ref;
      if (last_ref_r != {1'b0, new_ref}) begin
        last_ref_nxt = {1'b0, new_ref};
        dummy_nxt    = 1'b1;
        res_disc     = 1'b1;
      end else begin
        dummy_nxt = 1'b0;
      end
    end
  end

  assign stat.step_final = final_step;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_W'(25);
      auto_scale_r   <= 1'b1;
      vcc_mv_r       <= VCC_W'(5000);
      bandgap_mv_r   <= BG_W'(1100);
      busy_r         <= 1'b0;
      chan_r         <= '0;
      ref_r          <= 1'b0;
      last_ref_r     <= LREF_UNKNOWN;
      dummy_r        <= 1'b0;
      taken_r        <= '0;
      sum_r          <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SAMPLE_COUNT: sample_count_r <= cfg_data[CNT_W-1:0];
          REG_AUTO_SCALE:   auto_scale_r   <= cfg_data[0];
          REG_VCC_MV:       vcc_mv_r       <= cfg_data[VCC_W-1:0];
          REG_BANDGAP_MV:   bandgap_mv_r   <= cfg_data[BG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        busy_r     <= busy_nxt;
        chan_r     <= chan_nxt;
        ref_r      <= ref_nxt;
        last_ref_r <= last_ref_nxt;
        dummy_r    <= dummy_nxt;
        taken_r    <= taken_nxt;
        sum_r      <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r <= prod[PROD_W-1:ADC_BITS];
      rem_r <= '0;
    end else if (cmd.div) begin
      quo_r <= {quo_r[QUO_W-2:0], trial_ge};
      rem_r <= trial_ge ? CNT_W'(trial - {1'b0, n_eff}) : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && !final_step) begin
      o_kind_r <= res_kind;
      o_chan_r <= res_chan;
      o_ref_r  <= res_ref;
      o_disc_r <= res_disc;
      o_mv_r   <= '0;
    end else if (cmd.load_final) begin
      o_kind_r <= KIND_VOLTAGE;
      o_chan_r <= chan_r;
      o_ref_r  <= ref_r;
      o_disc_r <= 1'b0;
      o_mv_r   <= quo_r[MV_W-1:0];
    end
  end

  assign out_tuser = o_kind_r;
  assign out_tdata = {(OUT_TDATA_W - MV_W - CHAN_W - 2)'(0),
                      o_mv_r, o_disc_r, o_ref_r, o_chan_r};

endmodule

>>> src/adc_oversample_autorange.sv
// Top level of the averaged ADC measurement sequencer with auto reference.
// Results: a request or ignored-reading result is registered as its input is taken;
// the final reading of a measurement yields its voltage after a multiply step, the
// bit-serial divider steps and a load step that waits for a free output register.
// Throughput: one input transaction per cycle while the output is free or being taken,
// except after a final reading; input then waits until the voltage is in the output register.
// Reset (rst_n low, synchronous): registers to defaults, idle, last reference unknown.
module adc_oversample_autorange (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [adcor_pkg::IN_TDATA_W-1:0]     in_tdata,   // [4:0] channel, [14:5] sample
  input  logic                                 in_tuser,   // [0] mode
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [adcor_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [4:0] mux_channel, [5] ref_select,
                                                           // [6] discard_reading, [19:7] voltage_mv
  output logic [adcor_pkg::KIND_W-1:0]         out_tuser,  // [1:0] kind
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adcor_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adcor_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import adcor_pkg::*;

  adcor_cmd_t  cmd;
  adcor_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller: handshakes, output valid, multiply/divide sequencing
  adcor_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: registers, measurement state, sum, product, quotient, output payload
  adcor_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

>>> verif/adc_oversample_autorange_test.sv
// Self-checking stream testbench for the averaged ADC measurement sequencer.
module adc_oversample_autorange_test;
  import adcor_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int HOLD_CYCLES    = 400;     // long receiver hold-off for the pressure test
  localparam int TIMEOUT_CYCLES = 300000;

  typedef enum {RX_ALWAYS, RX_COIN, RX_CADENCE, RX_SLOW} rx_style_t;

  // one result as the block should present it
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic              refsel;
    logic              discard;
    logic [MV_W-1:0]   mv;
  } meas_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [4:0] channel, [14:5] sample
  logic                   in_tuser;    // [0] mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [4:0] mux_channel, [5] ref_select,
                                       // [6] discard_reading, [19:7] voltage_mv
  logic [KIND_W-1:0]      out_tuser;   // [1:0] kind
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DAT_W-1:0]   cfg_data;

  adc_oversample_autorange dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Measurement predictor: register copies and sequencer state, updated on each
  // accepted transaction. Expected results are queued in arrival order.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  count_cfg;
  logic              auto_cfg;
  logic [VCC_W-1:0]  vcc_cfg;
  logic [BG_W-1:0]   bg_cfg;

  bit                meas_busy;
  logic [CHAN_W-1:0] meas_chan;
  logic              meas_ref;       // 0 supply, 1 bandgap
  logic [LREF_W-1:0] meas_last_ref;  // reference of the last conversion, or unknown
  bit                meas_dummy;     // next reading is a throwaway
  logic [CNT_W-1:0]  meas_taken;
  logic [SUM_W-1:0]  meas_sum;

  meas_result_t expected_q[$];

  int        failures;
  int        counted_items;  // accepted items that were not merely ignored
  int        burst_left;
  bit        tx_gaps;
  bit        hold_req;
  rx_style_t rx_style;

  // Clear the sum and issue the first request; a reference change since the last
  // conversion costs one dummy conversion first.
  function automatic meas_result_t restart_summing();
    meas_result_t r;
    meas_sum   = '0;
    meas_taken = '0;
    r = '{kind: KIND_REQUEST, chan: meas_chan, refsel: meas_ref, discard: 1'b0, mv: '0};
    if (meas_last_ref != {1'b0, meas_ref}) begin
      meas_last_ref = {1'b0, meas_ref};
      meas_dummy    = 1'b1;
      r.discard     = 1'b1;
    end else begin
      meas_dummy = 1'b0;
    end
    return r;
  endfunction

  function automatic void predict_step(logic mode, logic [CHAN_W-1:0] chan,
                                       logic [ADC_BITS-1:0] smp);
    meas_result_t      r;
    logic [CNT_W-1:0]  n;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    r = '{kind: KIND_REQUEST, chan: meas_chan, refsel: meas_ref, discard: 1'b0, mv: '0};
    if (mode == MODE_START) begin
      // a start always begins fresh on supply, abandoning any running measurement
      meas_chan = chan;
      meas_ref  = 1'b0;
      meas_busy = 1'b1;
      r = restart_summing();
    end else if (!meas_busy) begin
      r = '{kind: KIND_IGNORED, chan: '0, refsel: 1'b0, discard: 1'b0, mv: '0};
    end else if (meas_dummy) begin
      meas_dummy = 1'b0;  // reading dropped, real request follows
    end else begin
      meas_sum = meas_sum + SUM_W'(smp);
      if (meas_taken == AUTO_CHECK_IDX && meas_sum < SUM_W'(1 << ADC_BITS) &&
          !meas_ref && auto_cfg) begin
        // low signal after five readings: redo on the bandgap reference
        meas_ref = 1'b1;
        r = restart_summing();
      end else begin
        meas_taken = meas_taken + 1'b1;
        n = (count_cfg == '0) ? CNT_W'(1) : count_cfg;
        if (meas_taken >= n) begin
          prod = PROD_W'(meas_sum) * PROD_W'(meas_ref ? VCC_W'(bg_cfg) : vcc_cfg);
          quo  = QUO_W'(prod >> ADC_BITS) / QUO_W'(n);
          meas_busy = 1'b0;
          r.kind = KIND_VOLTAGE;
          r.mv   = quo[MV_W-1:0];
        end
      end
    end
    if (r.kind != KIND_IGNORED) counted_items++;
    expected_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("adc_oversample_autorange: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input side. Handshakes are sampled at the falling edge, where every signal
  // is settled; the transaction then completes at the following rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic mode, logic [CHAN_W-1:0] chan, logic [ADC_BITS-1:0] smp);
    bit took;
    if (tx_gaps && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_TDATA_W'({smp, chan});
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    predict_step(mode, chan, smp);
    if (burst_left != 0) burst_left--;
  endtask

  // unused field of each item kind carries random junk
  task automatic send_start(logic [CHAN_W-1:0] chan);
    send_item(MODE_START, chan, ADC_BITS'($urandom));
  endtask

  task automatic send_reading(logic [ADC_BITS-1:0] smp);
    send_item(MODE_READING, CHAN_W'($urandom), smp);
  endtask

  // Well-formed measurement: start, then readings in [lo, hi] until the voltage.
  task automatic run_measurement(logic [CHAN_W-1:0] chan, int lo, int hi);
    send_start(chan);
    while (meas_busy) send_reading(ADC_BITS'($urandom_range(lo, hi)));
  endtask

  // Drain all outstanding results before touching the registers.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    bit took;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SAMPLE_COUNT: count_cfg = value[CNT_W-1:0];
      REG_AUTO_SCALE:   auto_cfg  = value[0];
      REG_VCC_MV:       vcc_cfg   = value[VCC_W-1:0];
      REG_BANDGAP_MV:   bg_cfg    = value[BG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int cnt, int autos, int vcc, int bg);
    write_reg(REG_SAMPLE_COUNT, CFG_DAT_W'(cnt));
    write_reg(REG_AUTO_SCALE,   CFG_DAT_W'(autos));
    write_reg(REG_VCC_MV,       CFG_DAT_W'(vcc));
    write_reg(REG_BANDGAP_MV,   CFG_DAT_W'(bg));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stall pattern, with a counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS:  out_tready <= 1'b1;
          RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
          RX_CADENCE: out_tready <= (tick % 5 != 0) && (tick % 7 != 3);
          default:    out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Each accepted result against the oldest expectation.
  always @(negedge clk) begin : result_check
    meas_result_t got;
    meas_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, chan: out_tdata[4:0], refsel: out_tdata[5],
              discard: out_tdata[6], mv: out_tdata[19:7]};
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result transaction: kind %0d tdata 'h%h", out_tuser, out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display({"result differs: expected kind %0d ch %0d ref %0d discard %0d mv %0d,",
                      " got kind %0d ch %0d ref %0d discard %0d mv %0d"},
                     want.kind, want.chan, want.refsel, want.discard, want.mv,
                     got.kind, got.chan, got.refsel, got.discard, got.mv);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-built sequence: idle reading, dummy on unknown reference, switch
  // to bandgap on a low sum, sum exactly at the threshold, abandoned start,
  // zero sample count, register change during a measurement.
  task automatic test_directed();
    send_reading(10'd1023);              // idle: ignored
    write_reg(REG_SAMPLE_COUNT, CFG_DAT_W'(5));
    write_reg(REG_VCC_MV, CFG_DAT_W'(6000));
    send_start(5'd31);                   // last reference unknown: dummy request
    send_reading(10'd1023);              // dummy reading thrown away
    repeat (4) send_reading(10'd0);
    send_reading(10'd1023);              // fifth reading, sum 1023: go to bandgap
    send_reading(10'd0);                 // dummy after the reference change
    repeat (5) send_reading(10'd1023);   // voltage on bandgap
    send_start(5'd0);                    // back to supply: dummy again
    send_reading(10'd512);
    repeat (4) send_reading(10'd205);
    send_reading(10'd204);               // sum exactly 1024: stays on supply
    send_reading(10'd1);                 // idle again
    send_start(5'd10);
    send_start(5'd21);                   // abandons channel 10
    write_reg(REG_VCC_MV, CFG_DAT_W'(8191));     // writes while a measurement is open
    write_reg(REG_SAMPLE_COUNT, CFG_DAT_W'(0));  // zero acts as one
    send_reading(10'd1023);
  endtask

  // Register extremes and a long 255-reading measurement.
  task automatic test_register_extremes();
    write_all(6, 0, 0, 2047);
    run_measurement(5'd7, 0, 10);        // low sum, auto scale off, zero supply
    write_reg(REG_AUTO_SCALE, CFG_DAT_W'(1));
    run_measurement(5'd8, 0, 100);       // switches to the top bandgap value
    write_reg(REG_BANDGAP_MV, CFG_DAT_W'(0));
    run_measurement(5'd9, 0, 50);
    write_all(255, 1, 6000, 2000);
    run_measurement(5'd30, 900, 1023);
    write_all(1, 1, 5000, 1100);
    repeat (3) run_measurement(CHAN_W'($urandom), 0, 1023);
    // shrink the sample count under a running measurement
    write_all(8, 0, 4096, 1100);
    send_start(5'd12);
    repeat (4) send_reading(ADC_BITS'($urandom_range(500, 1023)));
    write_reg(REG_SAMPLE_COUNT, CFG_DAT_W'(3));
    send_reading(ADC_BITS'($urandom_range(0, 1023)));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    write_all(12, 1, 5000, 1100);
    tx_gaps  = 1'b0;
    rx_style = RX_ALWAYS;
    hold_req = 1'b1;
    repeat (3) run_measurement(CHAN_W'($urandom), 0, 1023);
  endtask

  // Random phases: mostly complete measurements, some noise and cut-off ones.
  task automatic test_random();
    int phase;
    int goal;
    int pick;
    int lo;
    int hi;
    for (phase = 0; phase < 8; phase++) begin
      pick = $urandom_range(0, 9);
      write_all((pick == 0) ? 0 : (pick == 1) ? $urandom_range(11, 40) : $urandom_range(1, 10),
                $urandom_range(0, 1),
                ($urandom_range(0, 7) == 0) ? 8191 : $urandom_range(0, 6000),
                $urandom_range(0, 2047));
      tx_gaps  = ($urandom_range(0, 3) != 0);
      rx_style = rx_style_t'($urandom_range(0, 3));
      goal = counted_items + 25;
      while (counted_items < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          send_reading(ADC_BITS'($urandom));          // lone reading
        end else if (pick < 4) begin
          send_start(CHAN_W'($urandom));              // cut short, abandoned later
          repeat ($urandom_range(0, 6)) send_reading(ADC_BITS'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0:       begin lo = 0;   hi = 204;  end   // low: reference switch
            1:       begin lo = 195; hi = 215;  end   // around the threshold
            2:       begin lo = 800; hi = 1023; end
            default: begin lo = 0;   hi = 1023; end
          endcase
          run_measurement(CHAN_W'($urandom), lo, hi);
        end
      end
    end
  endtask

  initial begin
    // predictor at its reset state
    count_cfg     = CNT_W'(25);
    auto_cfg      = 1'b1;
    vcc_cfg       = VCC_W'(5000);
    bg_cfg        = BG_W'(1100);
    meas_busy     = 1'b0;
    meas_chan     = '0;
    meas_ref      = 1'b0;
    meas_last_ref = LREF_UNKNOWN;
    meas_dummy    = 1'b0;
    meas_taken    = '0;
    meas_sum      = '0;
    failures      = 0;
    counted_items = 0;
    burst_left    = 0;
    tx_gaps       = 1'b1;
    hold_req      = 1'b0;
    rx_style      = RX_COIN;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();

    // drain, then allow for a late stray result
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0 && expected_q.size() == 0)
      $display("adc_oversample_autorange: match");
    else
      $display("adc_oversample_autorange: mismatch");
    $finish;
  end

endmodule

>>> sim.f
src/adcor_pkg.sv
src/adcor_ctrl.sv
src/adcor_dp.sv
src/adc_oversample_autorange.sv
verif/adc_oversample_autorange_test.sv
